### src/tsp_pkg.sv
// Package for the triangular self-product block.
// Holds the item and command types, field widths and register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tsp_pkg;

	localparam int TSP_MAX_ORDER = 8;
	localparam int IDX_W = 3;
	localparam int ORD_W = 4;
	localparam int DATA_W = 16;
	localparam int ACC_W = 40;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_LOWER_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORDER = 1'd1;
	localparam logic [ORD_W-1:0] ORDER_RESET = 4'd8;

	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic signed [DATA_W-1:0] in_re;
		logic signed [DATA_W-1:0] in_im;
		logic load_last;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] out_row;
		logic [IDX_W-1:0] out_col;
		logic signed [ACC_W-1:0] out_re;
		logic signed [ACC_W-1:0] out_im;
		logic out_last;
	} out_item_t;

	typedef struct packed {
		logic issue;
		logic [IDX_W-1:0] a_row;
		logic [IDX_W-1:0] a_col;
		logic [IDX_W-1:0] b_row;
		logic [IDX_W-1:0] b_col;
		logic first;
		logic last;
		logic flip;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic elem_last;
	} tsp_cmd_t;

endpackage

`default_nettype wire

### src/triangular_self_product_top.sv
// Loads the stored triangle of an n by n complex Q1.15 matrix one element per
// item; an item marked last starts U*U^H (upper) or L^H*L (lower) and the
// result triangle is delivered row by row as exact 40-bit Q10.30 items.
// A load item is taken while the block is idle. For each result element the
// block reads both operands from the dual-read matrix store once per summation
// term and feeds one shared complex multiply-accumulate; the summation index of
// element (r,c) runs from c to n-1 in upper mode or from r to n-1 in lower mode.
// The next element starts only once the previous result is taken. No new item is
// accepted until the last result of the triangle has been delivered.
// Depends on tsp_pkg, tsp_ctrl and tsp_dp.
`timescale 1ns / 1ps
`default_nettype none

module triangular_self_product_top import tsp_pkg::*; #(
	parameter int MAX_ORDER = TSP_MAX_ORDER
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input wire logic in_valid,
	output logic in_ready,
	input wire in_item_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output out_item_t out_data
);

	tsp_cmd_t cmd;
	logic done;

	tsp_ctrl #(
		.MAX_ORDER(MAX_ORDER)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.load_last(in_data.load_last),
		.in_ready(in_ready),
		.cmd(cmd),
		.done(done)
	);

	tsp_dp #(
		.MAX_ORDER(MAX_ORDER)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.load_we(in_valid && in_ready),
		.load_item(in_data),
		.cmd(cmd),
		.done(done),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule

`default_nettype wire

### src/tsp_ram.sv
// Generic RAM with one write port and two registered read ports.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tsp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a,
	input wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

### src/tsp_ctrl.sv
// Controller of the triangular self-product block: configuration registers,
// loading handshake and the walk over result elements and summation index.
// Depends on tsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsp_ctrl import tsp_pkg::*; #(
	parameter int MAX_ORDER = TSP_MAX_ORDER
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input wire logic in_valid,
	input wire logic load_last,
	output logic in_ready,
	output tsp_cmd_t cmd,
	input wire logic done
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT
	} state_t;

	state_t state_q;
	logic lower_mode_q;
	logic [ORD_W-1:0] order_q;
	logic mode_q;
	logic [ORD_W-1:0] n_q;
	logic [IDX_W-1:0] r_q;
	logic [IDX_W-1:0] c_q;
	logic [IDX_W-1:0] k_q;

	logic [ORD_W-1:0] n_clamped;
	logic [IDX_W-1:0] n_last;
	logic [IDX_W-1:0] k_start;
	logic k_final;
	logic elem_final;
	logic [IDX_W-1:0] r_next;
	logic [IDX_W-1:0] c_next;

	assign n_clamped = (order_q > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : order_q;
	assign n_last = IDX_W'(n_q - 1'b1);
	assign k_start = mode_q ? r_q : c_q;
	assign k_final = (k_q == n_last);
	assign elem_final = mode_q ? ((r_q == n_last) && (c_q == r_q)) : (r_q == n_last);

	always_comb begin
		r_next = r_q;
		c_next = c_q;
		if (mode_q) begin
			if (c_q < r_q) begin
				c_next = c_q + 1'b1;
			end else begin
				r_next = r_q + 1'b1;
				c_next = '0;
			end
		end else begin
			if (c_q < n_last) begin
				c_next = c_q + 1'b1;
			end else begin
				r_next = r_q + 1'b1;
				c_next = r_q + 1'b1;
			end
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd.issue = (state_q == ST_ISSUE);
		cmd.a_row = mode_q ? k_q : r_q;
		cmd.a_col = mode_q ? r_q : k_q;
		cmd.b_row = mode_q ? k_q : c_q;
		cmd.b_col = mode_q ? c_q : k_q;
		cmd.first = (k_q == k_start);
		cmd.last = k_final;
		cmd.flip = mode_q;
		cmd.row = r_q;
		cmd.col = c_q;
		cmd.elem_last = elem_final;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lower_mode_q <= 1'b0;
			order_q <= ORDER_RESET;
			mode_q <= 1'b0;
			n_q <= '0;
			r_q <= '0;
			c_q <= '0;
			k_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_LOWER_MODE: lower_mode_q <= cfg_wdata[0];
					CFG_ORDER: order_q <= cfg_wdata[ORD_W-1:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid && load_last) begin
						mode_q <= lower_mode_q;
						n_q <= n_clamped;
						r_q <= '0;
						c_q <= '0;
						k_q <= '0;
						if (n_clamped != '0) begin
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_ISSUE: begin
					if (k_final) begin
						state_q <= ST_WAIT;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_WAIT: begin
					if (done) begin
						if (elem_final) begin
							state_q <= ST_IDLE;
						end else begin
							r_q <= r_next;
							c_q <= c_next;
							k_q <= mode_q ? r_next : c_next;
							state_q <= ST_ISSUE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

### src/tsp_dp.sv
// Datapath of the triangular self-product block: matrix store, complex
// multiply-accumulate pipeline and output register.
// Depends on tsp_pkg and tsp_ram.
`timescale 1ns / 1ps
`default_nettype none

module tsp_dp import tsp_pkg::*; #(
	parameter int MAX_ORDER = TSP_MAX_ORDER
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic load_we,
	input wire in_item_t load_item,
	input wire tsp_cmd_t cmd,
	output logic done,
	output logic out_valid,
	input wire logic out_ready,
	output out_item_t out_data
);

	localparam int DEPTH = MAX_ORDER * MAX_ORDER;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic in_range;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr_a;
	logic [ADDR_W-1:0] raddr_b;
	logic [2*DATA_W-1:0] rdata_a;
	logic [2*DATA_W-1:0] rdata_b;

	logic v_s1, first_s1, last_s1, flip_s1, adiag_s1, bdiag_s1, elast_s1;
	logic [IDX_W-1:0] row_s1, col_s1;
	logic v_s2, first_s2, last_s2, flip_s2, elast_s2;
	logic [IDX_W-1:0] row_s2, col_s2;
	logic signed [2*DATA_W-1:0] p_rr_s2, p_ii_s2, p_ib_s2, p_rb_s2;

	logic signed [DATA_W-1:0] ar, ai, br, bi;
	logic signed [ACC_W-1:0] re_term, im_term, acc_re_next, acc_im_next;
	logic signed [ACC_W-1:0] acc_re_q, acc_im_q;
	logic out_valid_q;
	out_item_t out_q;

	assign in_range = ({1'b0, load_item.row} < ORD_W'(MAX_ORDER))
		&& ({1'b0, load_item.col} < ORD_W'(MAX_ORDER));
	assign waddr = ADDR_W'(int'(load_item.row) * MAX_ORDER + int'(load_item.col));
	assign raddr_a = ADDR_W'(int'(cmd.a_row) * MAX_ORDER + int'(cmd.a_col));
	assign raddr_b = ADDR_W'(int'(cmd.b_row) * MAX_ORDER + int'(cmd.b_col));

	tsp_ram #(
		.WIDTH(2 * DATA_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk(clk),
		.we(load_we && in_range),
		.waddr(waddr),
		.wdata({load_item.in_im, load_item.in_re}),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	assign ar = rdata_a[DATA_W-1:0];
	assign ai = adiag_s1 ? '0 : rdata_a[2*DATA_W-1:DATA_W];
	assign br = rdata_b[DATA_W-1:0];
	assign bi = bdiag_s1 ? '0 : rdata_b[2*DATA_W-1:DATA_W];

	assign re_term = ACC_W'(p_rr_s2) + ACC_W'(p_ii_s2);
	assign im_term = flip_s2 ? (ACC_W'(p_rb_s2) - ACC_W'(p_ib_s2))
		: (ACC_W'(p_ib_s2) - ACC_W'(p_rb_s2));
	assign acc_re_next = first_s2 ? re_term : acc_re_q + re_term;
	assign acc_im_next = first_s2 ? im_term : acc_im_q + im_term;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			if (v_s2 && last_s2) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= cmd.first;
		last_s1 <= cmd.last;
		flip_s1 <= cmd.flip;
		adiag_s1 <= (cmd.a_row == cmd.a_col);
		bdiag_s1 <= (cmd.b_row == cmd.b_col);
		elast_s1 <= cmd.elem_last;
		row_s1 <= cmd.row;
		col_s1 <= cmd.col;

		first_s2 <= first_s1;
		last_s2 <= last_s1;
		flip_s2 <= flip_s1;
		elast_s2 <= elast_s1;
		row_s2 <= row_s1;
		col_s2 <= col_s1;
		p_rr_s2 <= ar * br;
		p_ii_s2 <= ai * bi;
		p_ib_s2 <= ai * br;
		p_rb_s2 <= ar * bi;

		if (v_s2) begin
			acc_re_q <= acc_re_next;
			acc_im_q <= acc_im_next;
		end
		if (v_s2 && last_s2) begin
			out_q.out_row <= row_s2;
			out_q.out_col <= col_s2;
			out_q.out_re <= acc_re_next;
			out_q.out_im <= (row_s2 == col_s2) ? '0 : acc_im_next;
			out_q.out_last <= elast_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign done = out_valid_q && out_ready;

endmodule

`default_nettype wire
